@@ rtl/max_k_digit_subsequence_sum_top_macros.svh @@
// Assertion helpers used by the top module.
`ifndef MAX_K_DIGIT_SUBSEQUENCE_SUM_TOP_MACROS_SVH
`define MAX_K_DIGIT_SUBSEQUENCE_SUM_TOP_MACROS_SVH

// same-cycle implication
`define MKDS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mkds assertion failed");

// next-cycle implication
`define MKDS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mkds assertion failed");

`endif

@@ rtl/mkds_pkg.sv @@
`timescale 1ns / 1ps

package mkds_pkg;

   localparam int DIGIT_W      = 4;
   localparam int LINE_VALUE_W = 40;
   localparam int TOTAL_W      = 63;
   localparam int ERR_W        = 2;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 104;
   localparam int RSP_USER_W   = 2;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_SHORT    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

   typedef struct packed {
      logic wr_en;
      logic start;
   } pick_ctrl_type;

endpackage

@@ rtl/mkds_pick.sv @@
`timescale 1ns / 1ps

module mkds_pick #(
   parameter int PICK_COUNT = 12,
   parameter int MAX_LINE   = 128,
   parameter int ADDR_W     = 7,
   parameter int LEN_W      = 8,
   parameter int VAL_W      = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mkds_pkg::pick_ctrl_type       ctrl,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [mkds_pkg::DIGIT_W-1:0]  wr_digit,
   input  logic [LEN_W-1:0]              len,
   output logic                          done,
   output logic [VAL_W-1:0]              value
);
   import mkds_pkg::*;

   localparam int PW = $clog2(PICK_COUNT + 1);

   logic [DIGIT_W-1:0] mem [MAX_LINE];

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               pend_ff, pend_in;
   logic               first_ff, first_in;
   logic [LEN_W-1:0]   issue_ff, issue_in;
   logic [LEN_W-1:0]   stop_ff, stop_in;
   logic [PW-1:0]      pick_ff, pick_in;
   logic [LEN_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [DIGIT_W-1:0] rd_data_ff;
   logic [DIGIT_W-1:0] best_ff, best_in;
   logic [LEN_W-1:0]   best_at_ff, best_at_in;
   logic [VAL_W-1:0]   value_ff, value_in;

   logic issue_more;
   logic window_end;
   logic take;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_digit;
      end
      rd_data_ff <= mem[issue_ff[ADDR_W-1:0]];
   end

   always_comb begin
      issue_more  = busy_ff && (issue_ff < stop_ff);
      window_end  = busy_ff && !issue_more && !pend_ff;
      take        = pend_ff && (first_ff || (rd_data_ff > best_ff));

      busy_in     = busy_ff;
      done_in     = 1'b0;
      pend_in     = 1'b0;
      first_in    = first_ff;
      issue_in    = issue_ff;
      stop_in     = stop_ff;
      pick_in     = pick_ff;
      pend_idx_in = pend_idx_ff;
      best_in     = best_ff;
      best_at_in  = best_at_ff;
      value_in    = value_ff;

      if (ctrl.start) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         issue_in = '0;
         stop_in  = len - LEN_W'(PICK_COUNT - 1);
         pick_in  = '0;
         value_in = '0;
      end else if (busy_ff) begin
         pend_in     = issue_more;
         pend_idx_in = issue_ff;
         if (issue_more) begin
            issue_in = issue_ff + LEN_W'(1);
         end
         if (take) begin
            best_in    = rd_data_ff;
            best_at_in = pend_idx_ff;
            first_in   = 1'b0;
         end
         if (window_end) begin
            value_in = VAL_W'({value_ff, 3'b000}) + VAL_W'({value_ff, 1'b0})
                       + VAL_W'(best_ff);
            issue_in = best_at_ff + LEN_W'(1);
            stop_in  = stop_ff + LEN_W'(1);
            first_in = 1'b1;
            pick_in  = pick_ff + PW'(1);
            if (pick_ff == PW'(PICK_COUNT - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         first_ff <= 1'b1;
         issue_ff <= '0;
         stop_ff  <= '0;
         pick_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         pend_ff  <= pend_in;
         first_ff <= first_in;
         issue_ff <= issue_in;
         stop_ff  <= stop_in;
         pick_ff  <= pick_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      best_ff     <= best_in;
      best_at_ff  <= best_at_in;
      value_ff    <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

@@ rtl/max_k_digit_subsequence_sum_top.sv @@
`timescale 1ns / 1ps
`include "max_k_digit_subsequence_sum_top_macros.svh"
// Largest PICK_COUNT-digit subsequence of each line of decimal digits, with a
// saturating running total over all valid lines.
// Request channel (req_): one digit per request, req_tlast on the last digit
// of a line. Digits above nine are taken as nine. A line holds up to MAX_LINE
// digits; further digits are dropped and the line is reported as overflowed.
// Response channel (rsp_): one response per line: line value, running total
// and error code (0 ok, 1 short line, 2 overflow). Error lines give value 0
// and leave the total as it was.
// Throughput: a digit is taken every cycle while a line loads. After the last
// digit, the pick engine scans the stored line through one compare unit and
// one memory read port, one digit per cycle: each pick p scans its window
// from start_p up to stop_p, then the line value is posted and added to the total.
// Error lines go straight to the response. req_tready is low while picking
// and while a finished response waits to be stored.
// Reset clears the total, the line counters and the response valid flag.
// A stalled response holds; the next line still loads behind it and waits
// only when its own response is ready.

module max_k_digit_subsequence_sum_top #(
   parameter int PICK_COUNT = 12,
   parameter int MAX_LINE   = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mkds_pkg::REQ_DATA_W-1:0]   req_tdata,  // [3:0] digit
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mkds_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [39:0] line_value,
                                                         // [102:40] running_total
   output logic [mkds_pkg::RSP_USER_W-1:0]   rsp_tuser   // [1:0] line_error
);
   import mkds_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LINE);
   localparam int LEN_W  = $clog2(MAX_LINE + 1);
   localparam int VAL_W  = (PICK_COUNT * 3322) / 1000 + 1;

   localparam logic [1:0] S_LOAD   = 2'd0;
   localparam logic [1:0] S_PICK   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    ovf_ff, ovf_in;
   logic [ERR_W-1:0]        err_ff, err_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LINE_VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [TOTAL_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [ERR_W-1:0]        rsp_err_ff, rsp_err_in;

   pick_ctrl_type           pick_ctrl;
   logic                    pick_done;
   logic [VAL_W-1:0]        pick_value;

   logic                    req_acc;
   logic                    room;
   logic [DIGIT_W-1:0]      digit_sat;
   logic [LEN_W-1:0]        len_next;
   logic [VAL_W-1:0]        line_val;
   logic [TOTAL_W:0]        sum;
   logic [TOTAL_W-1:0]      new_total;
   logic                    rsp_free;

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign room       = (len_ff < LEN_W'(MAX_LINE));
   assign digit_sat  = (req_tdata[DIGIT_W-1:0] > DIGIT_MAX) ? DIGIT_MAX
                                                            : req_tdata[DIGIT_W-1:0];
   assign len_next   = room ? (len_ff + LEN_W'(1)) : len_ff;
   assign line_val   = (err_ff == ERR_OK) ? pick_value : '0;
   assign sum        = {1'b0, total_ff} + (TOTAL_W + 1)'(line_val);
   assign new_total  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   mkds_pick #(
      .PICK_COUNT (PICK_COUNT),
      .MAX_LINE   (MAX_LINE),
      .ADDR_W     (ADDR_W),
      .LEN_W      (LEN_W),
      .VAL_W      (VAL_W)
   ) u_pick (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (pick_ctrl),
      .wr_addr  (len_ff[ADDR_W-1:0]),
      .wr_digit (digit_sat),
      .len      (len_next),
      .done     (pick_done),
      .value    (pick_value)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      err_in       = err_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_total_in = rsp_total_ff;
      rsp_err_in   = rsp_err_ff;
      pick_ctrl.wr_en = req_acc && room;
      pick_ctrl.start = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               len_in = len_next;
               ovf_in = ovf_ff || !room;
               if (req_tlast) begin
                  len_in = '0;
                  ovf_in = 1'b0;
                  if (ovf_ff || !room) begin
                     err_in   = ERR_OVERFLOW;
                     state_in = S_FINISH;
                  end else if (len_next < LEN_W'(PICK_COUNT)) begin
                     err_in   = ERR_SHORT;
                     state_in = S_FINISH;
                  end else begin
                     err_in          = ERR_OK;
                     pick_ctrl.start = 1'b1;
                     state_in        = S_PICK;
                  end
               end
            end
         end
         S_PICK: begin
            if (pick_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = LINE_VALUE_W'(line_val);
               rsp_total_in = new_total;
               rsp_err_in   = err_ff;
               total_in     = new_total;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_total_ff <= rsp_total_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_total_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_err_ff;

   `MKDS_ASSERT_IMP(a_done_in_pick, clock, reset, pick_done, state_ff == S_PICK)
   `MKDS_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid_ff && (rsp_err_ff != ERR_OK),
                    rsp_value_ff == '0)
   `MKDS_ASSERT_IMP(a_total_grows, clock, reset, !$past(reset),
                    total_ff >= $past(total_ff))
   `MKDS_ASSERT_NXT(a_finish_posts, clock, reset, (state_ff == S_FINISH) && rsp_free,
                    rsp_valid_ff && (state_ff == S_LOAD))

endmodule
